/* src/ots_pkg.sv */
`default_nettype none
package ots_pkg;

	typedef logic signed [18:0] ang_t;
	typedef logic signed [33:0] trig_t;
	typedef logic signed [31:0] pos_t;

	localparam logic signed [19:0] ANG_PI      = 20'sd102944;
	localparam logic signed [19:0] ANG_TWO_PI  = 20'sd205887;
	localparam logic signed [19:0] ANG_HALF_PI = 20'sd51472;
	localparam logic [15:0]        SMOOTH_LIMIT = 16'd64880;
	localparam trig_t              CORDIC_GAIN  = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_EL_MIN   = 3'd0,
		REG_EL_MAX   = 3'd1,
		REG_DIST_MIN = 3'd2,
		REG_DIST_MAX = 3'd3,
		REG_DIST_DEF = 3'd4,
		REG_SMOOTH   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_HORIZ = 3'd0,
		OP_PY    = 3'd1,
		OP_PX    = 3'd2,
		OP_PZ    = 3'd3,
		OP_MX    = 3'd4,
		OP_MY    = 3'd5,
		OP_MZ    = 3'd6
	} mul_op_t;

	// arctan(2^-i) in Q.20
	function automatic logic signed [23:0] atan_q20(input logic [3:0] i);
		case (i)
			4'd0:    atan_q20 = 24'sd823550;
			4'd1:    atan_q20 = 24'sd486170;
			4'd2:    atan_q20 = 24'sd256879;
			4'd3:    atan_q20 = 24'sd130396;
			4'd4:    atan_q20 = 24'sd65451;
			4'd5:    atan_q20 = 24'sd32757;
			4'd6:    atan_q20 = 24'sd16383;
			4'd7:    atan_q20 = 24'sd8192;
			4'd8:    atan_q20 = 24'sd4096;
			4'd9:    atan_q20 = 24'sd2048;
			4'd10:   atan_q20 = 24'sd1024;
			4'd11:   atan_q20 = 24'sd512;
			4'd12:   atan_q20 = 24'sd256;
			4'd13:   atan_q20 = 24'sd128;
			4'd14:   atan_q20 = 24'sd64;
			default: atan_q20 = 24'sd32;
		endcase
	endfunction

	function automatic pos_t sat32(input logic signed [37:0] v);
		if (v > 38'sd2147483647)
			sat32 = 32'sh7fffffff;
		else if (v < -38'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

endpackage
`default_nettype wire

/* src/ots_item_if.sv */
`default_nettype none
interface ots_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] entity_x;
	logic signed [31:0] entity_y;
	logic signed [31:0] entity_z;
	logic signed [17:0] azimuth_step;
	logic signed [17:0] elevation_step;
	logic signed [31:0] distance_step;

	modport source(output valid, entity_x, entity_y, entity_z, azimuth_step,
		elevation_step, distance_step, input ready);
	modport sink(input valid, entity_x, entity_y, entity_z, azimuth_step,
		elevation_step, distance_step, output ready);
endinterface
`default_nettype wire

/* src/ots_result_if.sv */
`default_nettype none
interface ots_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;

	modport source(output valid, target_x, target_y, target_z, input ready);
	modport sink(input valid, target_x, target_y, target_z, output ready);
endinterface
`default_nettype wire

/* src/ots_cordic.sv */
`default_nettype none
module ots_cordic import ots_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire ang_t  angle,
	output logic       done,
	output trig_t      sin_val,
	output trig_t      cos_val
);
	logic signed [19:0] ang_ext;
	logic signed [19:0] ang_fold;
	logic               fold;
	trig_t              x_q, y_q;
	logic signed [23:0] z_q;
	logic [3:0]         step_q;
	logic               run_q, neg_q, done_q;

	// fold the angle by pi into [-pi/2, pi/2]
	always_comb begin
		ang_ext  = 20'(angle);
		fold     = 1'b0;
		ang_fold = ang_ext;
		if (ang_ext > ANG_HALF_PI) begin
			ang_fold = ang_ext - ANG_PI;
			fold     = 1'b1;
		end else if (ang_ext < -ANG_HALF_PI) begin
			ang_fold = ang_ext + ANG_PI;
			fold     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= 24'({ang_fold, 5'b0});
			neg_q <= fold;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> step_q);
				y_q <= y_q + (x_q >>> step_q);
				z_q <= z_q - atan_q20(step_q);
			end else begin
				x_q <= x_q + (y_q >>> step_q);
				y_q <= y_q - (x_q >>> step_q);
				z_q <= z_q + atan_q20(step_q);
			end
		end
	end

	assign done    = done_q;
	assign sin_val = neg_q ? -y_q : y_q;
	assign cos_val = neg_q ? -x_q : x_q;

endmodule
`default_nettype wire

/* src/ots_mul.sv */
`default_nettype none
module ots_mul import ots_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [33:0] a,
	input  wire logic signed [33:0] b,
	output logic                    done,
	output logic signed [67:0]      prod
);
	logic               hi_q, done_q;
	logic signed [17:0] digit;
	logic signed [51:0] part;
	logic signed [67:0] acc_q;

	// low digit unsigned, high digit signed
	assign digit = hi_q ? 18'($signed(b[33:17])) : $signed({1'b0, b[16:0]});
	assign part  = a * digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= hi_q;
			hi_q   <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			acc_q <= 68'(part);
		else if (hi_q)
			acc_q <= acc_q + (68'(part) <<< 17);
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

/* src/orbit_target_spherical_smoother.sv */
// Orbit look-target smoother. Each request carries an entity position and
// steps for azimuth, elevation and distance; the block keeps the orbit, wraps
// azimuth once into [-pi, pi], clamps elevation and distance to the limits in
// the register file, turns the orbit into a Cartesian offset with sine and
// cosine from one shared 16-step CORDIC, and moves the kept world position
// toward entity plus offset by (1 - smoothing). One request is worked at a
// time: two CORDIC passes, elevation then azimuth; four products with
// smoothing at zero or seven with it on, on one 34x18 multiplier; a load of
// the output register; then the next request is taken. The input is not
// ready while a request is worked; a finished result sits in an output
// register while the next request is taken. Registers (APB, byte address
// 4*i): elevation_min, elevation_max, distance_min, distance_max,
// default_distance, smoothing.
`default_nettype none
module orbit_target_spherical_smoother import ots_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	ots_item_if.sink         item,
	ots_result_if.source     result
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_COR_EL = 5'b00010,
		ST_COR_AZ = 5'b00100,
		ST_MUL    = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q;

	// register file
	logic signed [16:0] el_min_q, el_max_q;
	logic [30:0]        dmin_q, dmax_q, ddef_q;
	logic [15:0]        smooth_q;

	// orbit and world state
	logic  started_q;
	ang_t  az_q, el_q;
	pos_t  d_q;
	pos_t  wx_q, wy_q, wz_q;
	pos_t  ex_q, ey_q, ez_q;

	// working values
	trig_t              sel_q, cel_q, saz_q, caz_q;
	logic signed [33:0] horiz_q;
	logic signed [35:0] px_q, py_q;
	pos_t               tx_q, ty_q, tz_q;
	mul_op_t            op_q;
	logic               cor_go_q, mul_go_q;

	// output register
	logic rv_q;
	pos_t ox_q, oy_q, oz_q;

	logic accept, cfg_wr, out_load;
	assign accept = item.valid && item.ready;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!rv_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_min_q <= -17'sd45000;
			el_max_q <= 17'sd45000;
			dmin_q   <= 31'd65536;
			dmax_q   <= 31'd6553600;
			ddef_q   <= 31'd655360;
			smooth_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_EL_MIN:   el_min_q <= pwdata[16:0];
				REG_EL_MAX:   el_max_q <= pwdata[16:0];
				REG_DIST_MIN: dmin_q   <= pwdata[30:0];
				REG_DIST_MAX: dmax_q   <= pwdata[30:0];
				REG_DIST_DEF: ddef_q   <= pwdata[30:0];
				REG_SMOOTH:   smooth_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_EL_MIN:   prdata = 32'(el_min_q);
			REG_EL_MAX:   prdata = 32'(el_max_q);
			REG_DIST_MIN: prdata = {1'b0, dmin_q};
			REG_DIST_MAX: prdata = {1'b0, dmax_q};
			REG_DIST_DEF: prdata = {1'b0, ddef_q};
			REG_SMOOTH:   prdata = {16'b0, smooth_q};
			default:      prdata = '0;
		endcase
	end

	// orbit update, applied when a request is taken
	ang_t               az_base, el_base;
	logic signed [19:0] az_sum, el_sum, az_wrap, el_lo, el_clamp;
	logic signed [33:0] d_base, d_sum, d_sat, d_lo, d_clamp;

	always_comb begin
		az_base = started_q ? az_q : '0;
		el_base = started_q ? el_q : '0;
		d_base  = started_q ? 34'(d_q) : 34'({1'b0, ddef_q});

		az_sum  = 20'(az_base) + 20'(item.azimuth_step);
		az_wrap = az_sum;
		if (az_sum > ANG_PI)
			az_wrap = az_sum - ANG_TWO_PI;
		else if (az_sum < -ANG_PI)
			az_wrap = az_sum + ANG_TWO_PI;

		// lower bound first, so inverted limits give the upper one
		el_sum   = 20'(el_base) + 20'(item.elevation_step);
		el_lo    = (el_sum < 20'(el_min_q)) ? 20'(el_min_q) : el_sum;
		el_clamp = (el_lo > 20'(el_max_q)) ? 20'(el_max_q) : el_lo;

		d_sum = d_base + 34'(item.distance_step);
		d_sat = d_sum;
		if (d_sum > 34'sd2147483647)
			d_sat = 34'sd2147483647;
		else if (d_sum < -34'sd2147483648)
			d_sat = -34'sd2147483648;
		d_lo    = (d_sat < $signed({3'b0, dmin_q})) ? $signed({3'b0, dmin_q}) : d_sat;
		d_clamp = (d_lo > $signed({3'b0, dmax_q})) ? $signed({3'b0, dmax_q}) : d_lo;
	end

	// shared CORDIC
	logic  cor_start, cor_done;
	trig_t cor_sin, cor_cos;
	ang_t  cor_ang;

	assign cor_start = accept || cor_go_q;
	assign cor_ang   = (state_q == ST_IDLE) ? ang_t'(el_clamp[18:0]) : az_q;

	ots_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_ang),
		.done    (cor_done),
		.sin_val (cor_sin),
		.cos_val (cor_cos)
	);

	// shared multiplier, operands picked by the current product
	logic [15:0]        keep;
	logic signed [33:0] mul_a, mul_b;
	logic               mul_done;
	logic signed [67:0] mul_p, mul_rnd;
	logic signed [35:0] rnd;

	assign keep = (smooth_q > SMOOTH_LIMIT) ? SMOOTH_LIMIT : smooth_q;

	always_comb begin
		case (op_q)
			OP_HORIZ: begin mul_a = 34'(d_q);   mul_b = cel_q; end
			OP_PY:    begin mul_a = 34'(d_q);   mul_b = sel_q; end
			OP_PX:    begin mul_a = horiz_q;   mul_b = saz_q; end
			OP_PZ:    begin mul_a = horiz_q;   mul_b = caz_q; end
			OP_MX:    begin mul_a = 34'(tx_q) - 34'(wx_q); mul_b = 34'(17'd65536 - 17'(keep)); end
			OP_MY:    begin mul_a = 34'(ty_q) - 34'(wy_q); mul_b = 34'(17'd65536 - 17'(keep)); end
			OP_MZ:    begin mul_a = 34'(tz_q) - 34'(wz_q); mul_b = 34'(17'd65536 - 17'(keep)); end
			default:  begin mul_a = '0;        mul_b = '0;    end
		endcase
	end

	ots_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	// round half up: products with a Q4.30 sine or cosine drop 30 bits, smoothing steps drop 16
	always_comb begin
		if (op_q == OP_MX || op_q == OP_MY || op_q == OP_MZ)
			mul_rnd = (mul_p + 68'sd32768) >>> 16;
		else
			mul_rnd = (mul_p + 68'sd536870912) >>> 30;
		rnd = mul_rnd[35:0];
	end

	pos_t tz_new;
	assign tz_new = sat32(38'(ez_q) - 38'(rnd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			az_q      <= '0;
			el_q      <= '0;
			d_q       <= '0;
			wx_q      <= '0;
			wy_q      <= '0;
			wz_q      <= '0;
			op_q      <= OP_HORIZ;
			cor_go_q  <= 1'b0;
			mul_go_q  <= 1'b0;
			rv_q      <= 1'b0;
		end else begin
			cor_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			// load the output register, or drop it once taken
			if (out_load)
				rv_q <= 1'b1;
			else if (result.ready)
				rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// first request loads the orbit from the default distance
						if (!started_q) begin
							wx_q <= '0;
							wy_q <= '0;
							wz_q <= 32'(-$signed({1'b0, ddef_q}));
						end
						started_q <= 1'b1;
						az_q      <= az_wrap[18:0];
						el_q      <= el_clamp[18:0];
						d_q       <= d_clamp[31:0];
						op_q      <= OP_HORIZ;
						state_q   <= ST_COR_EL;
					end
				end
				ST_COR_EL: begin
					if (cor_done) begin
						cor_go_q <= 1'b1;
						state_q  <= ST_COR_AZ;
					end
				end
				ST_COR_AZ: begin
					if (cor_done) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						case (op_q)
							OP_HORIZ: begin
								op_q     <= OP_PY;
								mul_go_q <= 1'b1;
							end
							OP_PY: begin
								op_q     <= OP_PX;
								mul_go_q <= 1'b1;
							end
							OP_PX: begin
								op_q     <= OP_PZ;
								mul_go_q <= 1'b1;
							end
							OP_PZ: begin
								if (keep == '0) begin
									// no smoothing: jump to the target
									wx_q    <= sat32(38'(ex_q) + 38'(px_q));
									wy_q    <= sat32(38'(ey_q) + 38'(py_q));
									wz_q    <= tz_new;
									state_q <= ST_OUT;
								end else begin
									op_q     <= OP_MX;
									mul_go_q <= 1'b1;
								end
							end
							OP_MX: begin
								wx_q     <= sat32(38'(wx_q) + 38'(rnd));
								op_q     <= OP_MY;
								mul_go_q <= 1'b1;
							end
							OP_MY: begin
								wy_q     <= sat32(38'(wy_q) + 38'(rnd));
								op_q     <= OP_MZ;
								mul_go_q <= 1'b1;
							end
							OP_MZ: begin
								wz_q    <= sat32(38'(wz_q) + 38'(rnd));
								state_q <= ST_OUT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ex_q <= item.entity_x;
			ey_q <= item.entity_y;
			ez_q <= item.entity_z;
		end
		if (state_q == ST_COR_EL && cor_done) begin
			sel_q <= cor_sin;
			cel_q <= cor_cos;
		end
		if (state_q == ST_COR_AZ && cor_done) begin
			saz_q <= cor_sin;
			caz_q <= cor_cos;
		end
		if (state_q == ST_MUL && mul_done) begin
			case (op_q)
				OP_HORIZ: horiz_q <= rnd[33:0];
				OP_PY:    py_q    <= rnd;
				OP_PX:    px_q    <= rnd;
				OP_PZ: begin
					tx_q <= sat32(38'(ex_q) + 38'(px_q));
					ty_q <= sat32(38'(ey_q) + 38'(py_q));
					tz_q <= tz_new;
				end
				default: ;
			endcase
		end
		if (out_load) begin
			ox_q <= wx_q;
			oy_q <= wy_q;
			oz_q <= wz_q;
		end
	end

	assign result.valid    = rv_q;
	assign result.target_x = ox_q;
	assign result.target_y = oy_q;
	assign result.target_z = oz_q;

	a_mul_go_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go_q |-> (state_q == ST_MUL))
		else $error("multiplier started outside the product phase");

	a_cor_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_COR_EL || state_q == ST_COR_AZ))
		else $error("CORDIC finished outside a CORDIC phase");

	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> started_q)
		else $error("orbit not marked started after a request");

endmodule
`default_nettype wire
